### hdl/qspc_pkg.sv
// Shared types and constants for the quadrature speed PID controller.
// No dependencies; qspc_pid and the top level import it.
package qspc_pkg;

    // Position count rests here after every sample tick.
    localparam logic [31:0] COUNT_CENTER = 32'd10000;
    localparam logic [15:0] SPEED_MAX    = 16'd62499;

    // Base-250 speed digits. The quotient uses a reciprocal multiply:
    // (x * 67109) >> 24 equals x / 250 for every x below 493000.
    localparam int          DIGIT_BASE   = 250;
    localparam logic [16:0] DIGIT_RECIP  = 17'd67109;
    localparam int          DIGIT_SHIFT  = 24;

    // Configuration port.
    localparam int ADDR_W = 5;

    localparam logic        COUNT_MODE_RST   = 1'b0;
    localparam logic [15:0] KP_GAIN_RST      = 16'd1792;
    localparam logic [15:0] KI_GAIN_RST      = 16'd5;
    localparam logic [15:0] KD_GAIN_RST      = 16'd2560;
    localparam logic [9:0]  DRIVE_MAX_RST    = 10'd399;
    localparam logic [7:0]  REPORT_EVERY_RST = 8'd5;

    typedef enum logic [1:0] {
        REQ_EDGE_A = 2'd0,
        REQ_EDGE_B = 2'd1,
        REQ_TICK   = 2'd2
    } t_req_type;

    typedef enum logic [2:0] {
        REG_COUNT_MODE   = 3'd0,
        REG_KP_GAIN      = 3'd1,
        REG_KI_GAIN      = 3'd2,
        REG_KD_GAIN      = 3'd3,
        REG_DRIVE_MAX    = 3'd4,
        REG_REPORT_EVERY = 3'd5
    } t_reg_idx;

    // Stage moves and tick flags handed from the pipeline control to the PID datapath.
    typedef struct packed {
        logic ld2;    // item moves from stage 1 to stage 2
        logic ld3;    // stage 2 to stage 3
        logic ld4;    // stage 3 to stage 4
        logic ldo;    // stage 4 to the output register
        logic tick1;  // item in stage 1 is a sample tick
        logic tick4;  // item in stage 4 is a sample tick
    } t_pid_ctrl;

endpackage

### hdl/qspc_if.sv
// Request and response channel interfaces of the quadrature speed PID controller.
// Depends on nothing; payload widths follow the block's field list.
interface qspc_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic        level_a;
    logic        level_b;
    logic [15:0] target_speed;

    modport source (output valid, req_type, level_a, level_b, target_speed, input ready);
    modport sink   (input valid, req_type, level_a, level_b, target_speed, output ready);
endinterface

interface qspc_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] position_count;
    logic [15:0] speed_magnitude;
    logic        direction;
    logic [9:0]  drive_duty;
    logic [7:0]  speed_high_digit;
    logic [7:0]  speed_low_digit;
    logic        report_due;

    modport source (output valid, position_count, speed_magnitude, direction, drive_duty,
                    speed_high_digit, speed_low_digit, report_due, input ready);
    modport sink   (input valid, position_count, speed_magnitude, direction, drive_duty,
                    speed_high_digit, speed_low_digit, report_due, output ready);
endinterface

### hdl/qspc_pid.sv
// Incremental PID datapath: error history, gain products, delta sum and clamped accumulator.
// Depends on qspc_pkg; stepped by the pipeline control in the top level.
module qspc_pid import qspc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_pid_ctrl   i_ctrl,
    input  logic [15:0] i_target,
    input  logic [15:0] i_speed,
    input  logic [15:0] i_kp,
    input  logic [15:0] i_ki,
    input  logic [15:0] i_kd,
    input  logic [9:0]  i_drive_max,
    output logic [9:0]  o_duty
);

    logic signed [16:0] r_err_now;
    logic signed [16:0] r_err_prev;
    logic signed [16:0] n_err;
    logic signed [17:0] n_d1;
    logic signed [17:0] n_d2;
    logic signed [18:0] n_d3;
    logic signed [17:0] r_d1;
    logic signed [17:0] r_d2;
    logic signed [18:0] r_d3;
    logic signed [35:0] r_p1;
    logic signed [35:0] r_p2;
    logic signed [35:0] r_p3;
    logic signed [37:0] r_delta;
    logic        [17:0] r_accum;
    logic signed [38:0] n_sum;
    logic        [17:0] n_top;
    logic        [17:0] n_accum;

    // Stage 2 inputs: new error and the three terms formed from it and the error history.
    always_comb begin
        n_err = $signed({1'b0, i_target}) - $signed({1'b0, i_speed});
        n_d1  = 18'(n_err) - 18'(r_err_now);
        n_d2  = 18'(n_err) + 18'(r_err_now);
        n_d3  = 19'(n_err) - (19'(r_err_now) <<< 1) + 19'(r_err_prev);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_err_now  <= '0;
            r_err_prev <= '0;
            r_accum    <= '0;
        end else begin
            if (i_ctrl.ld2 && i_ctrl.tick1) begin
                r_err_prev <= r_err_now;
                r_err_now  <= n_err;
            end
            if (i_ctrl.ldo && i_ctrl.tick4) begin
                r_accum <= n_accum;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.ld2) begin
            r_d1 <= n_d1;
            r_d2 <= n_d2;
            r_d3 <= n_d3;
        end
        if (i_ctrl.ld3) begin
            r_p1 <= 36'($signed({1'b0, i_kp}) * r_d1);
            r_p2 <= 36'($signed({1'b0, i_ki}) * r_d2);
            r_p3 <= 36'($signed({1'b0, i_kd}) * r_d3);
        end
        if (i_ctrl.ld4) begin
            r_delta <= 38'(r_p1) + 38'(r_p2) + 38'(r_p3);
        end
    end

    // Accumulate and clamp to 0 .. drive_max in Q.8.
    always_comb begin
        n_sum = $signed({21'd0, r_accum}) + 39'(r_delta);
        n_top = {i_drive_max, 8'h00};
        if (n_sum < 0) begin
            n_accum = '0;
        end else if (n_sum > $signed({21'd0, n_top})) begin
            n_accum = n_top;
        end else begin
            n_accum = n_sum[17:0];
        end
    end

    assign o_duty = i_ctrl.tick4 ? n_accum[17:8] : r_accum[17:8];

endmodule

### hdl/quadrature_speed_pid_controller.sv
// Top level of the quadrature speed PID controller: edge counting, tick latch, pipeline and APB.
// Depends on qspc_pkg, qspc_if and qspc_pid.
//
//   channel   direction  handshake            carries
//   i_req     in         valid / ready        req_type, level_a, level_b, target_speed
//   o_rsp     out        valid / ready        count, speed, direction, duty, digits, report
//   apb       in         psel/penable/pready  six registers at byte address 4*index
//
// One request per cycle unless the full pipeline is held by an output stall; every request gives exactly one response.
// Five register stages, stages 1 to 4 and the output register; a response is valid from the output register.
// The position count and tick latch update as a request is taken; the PID accumulator
// updates as a tick leaves the last stage for the output register.
// Stages advance independently, so bubbles close up under output stalls.
// Synchronous reset gives control, state and config registers their documented values, not stage data.
module quadrature_speed_pid_controller import qspc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    qspc_req_if.sink          i_req,
    qspc_rsp_if.source        o_rsp,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    typedef struct packed {
        logic [31:0] pos;
        logic [15:0] speed;
        logic        dir;
        logic        report;
        logic        tick;
        logic [15:0] target;
    } t_s1;

    typedef struct packed {
        logic [31:0] pos;
        logic [15:0] speed;
        logic        dir;
        logic        report;
        logic        tick;
        logic [7:0]  high;
        logic [7:0]  low;
    } t_stage;

    // Configuration registers.
    logic        r_count_mode;
    logic [15:0] r_kp;
    logic [15:0] r_ki;
    logic [15:0] r_kd;
    logic [9:0]  r_drive_max;
    logic [7:0]  r_report_every;

    // Block state.
    logic [31:0] r_edge_count;
    logic [15:0] r_speed;
    logic        r_dir;
    logic [7:0]  r_report_cnt;

    logic [31:0] n_edge_count;
    logic [15:0] n_speed;
    logic        n_dir;
    logic [7:0]  n_report_cnt;
    logic        n_report;
    logic        n_tick;
    logic [31:0] n_diff;
    logic [31:0] n_mag;

    // Pipeline.
    logic        r_v1, r_v2, r_v3, r_v4, r_ov;
    t_s1         r_s1;
    t_stage      r_s2, r_s3, r_s4;
    t_stage      r_out;
    t_stage      n_s3;
    logic [9:0]  r_out_duty;
    logic [32:0] n_qprod;
    logic [15:0] n_qmul;

    logic        acc;
    logic        ld2, ld3, ld4, ld_out;
    logic        cfg_wr;
    t_pid_ctrl   pid_ctrl;
    logic [9:0]  pid_duty;

    assign acc    = i_req.valid && i_req.ready;
    assign ld_out = r_v4 && (!r_ov || o_rsp.ready);
    assign ld4    = r_v3 && (!r_v4 || ld_out);
    assign ld3    = r_v2 && (!r_v3 || ld4);
    assign ld2    = r_v1 && (!r_v2 || ld3);
    assign i_req.ready = !r_v1 || ld2;

    // Request decode: edge counting, tick latch and report divider.
    always_comb begin
        n_edge_count = r_edge_count;
        n_speed      = r_speed;
        n_dir        = r_dir;
        n_report_cnt = r_report_cnt;
        n_report     = 1'b0;
        n_tick       = 1'b0;
        n_diff       = r_edge_count - COUNT_CENTER;
        n_mag        = n_diff[31] ? (32'd0 - n_diff) : n_diff;
        case (t_req_type'(i_req.req_type))
            REQ_EDGE_A: begin
                if (r_count_mode || i_req.level_a) begin
                    n_edge_count = (i_req.level_a != i_req.level_b) ?
                                   r_edge_count + 32'd1 : r_edge_count - 32'd1;
                end
            end
            REQ_EDGE_B: begin
                if (r_count_mode) begin
                    n_edge_count = (i_req.level_a == i_req.level_b) ?
                                   r_edge_count + 32'd1 : r_edge_count - 32'd1;
                end
            end
            REQ_TICK: begin
                n_tick       = 1'b1;
                n_dir        = n_diff[31];
                n_speed      = (n_mag > 32'(SPEED_MAX)) ? SPEED_MAX : n_mag[15:0];
                n_edge_count = COUNT_CENTER;
                if (r_report_cnt == r_report_every) begin
                    n_report     = 1'b1;
                    n_report_cnt = '0;
                end else begin
                    n_report_cnt = r_report_cnt + 8'd1;
                end
            end
            default: begin
            end
        endcase
    end

    // Control and state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_edge_count <= COUNT_CENTER;
            r_speed      <= '0;
            r_dir        <= 1'b0;
            r_report_cnt <= '0;
            r_v1         <= 1'b0;
            r_v2         <= 1'b0;
            r_v3         <= 1'b0;
            r_v4         <= 1'b0;
            r_ov         <= 1'b0;
        end else begin
            if (acc) begin
                r_edge_count <= n_edge_count;
                r_speed      <= n_speed;
                r_dir        <= n_dir;
                r_report_cnt <= n_report_cnt;
            end
            r_v1 <= acc || (r_v1 && !ld2);
            r_v2 <= ld2 || (r_v2 && !ld3);
            r_v3 <= ld3 || (r_v3 && !ld4);
            r_v4 <= ld4 || (r_v4 && !ld_out);
            r_ov <= ld_out || (r_ov && !o_rsp.ready);
        end
    end

    // Digit split: reciprocal multiply in stage 2, remainder in stage 3.
    assign n_qprod = 33'(r_s1.speed * DIGIT_RECIP);
    assign n_qmul  = 16'(r_s2.high) * 16'(DIGIT_BASE);

    always_comb begin
        n_s3     = r_s2;
        n_s3.low = 8'(r_s2.speed - n_qmul);
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_s1.pos    <= n_edge_count;
            r_s1.speed  <= n_speed;
            r_s1.dir    <= n_dir;
            r_s1.report <= n_report;
            r_s1.tick   <= n_tick;
            r_s1.target <= i_req.target_speed;
        end
        if (ld2) begin
            r_s2.pos    <= r_s1.pos;
            r_s2.speed  <= r_s1.speed;
            r_s2.dir    <= r_s1.dir;
            r_s2.report <= r_s1.report;
            r_s2.tick   <= r_s1.tick;
            r_s2.high   <= n_qprod[DIGIT_SHIFT+7:DIGIT_SHIFT];
            r_s2.low    <= '0;
        end
        if (ld3) begin
            r_s3 <= n_s3;
        end
        if (ld4) begin
            r_s4 <= r_s3;
        end
        if (ld_out) begin
            r_out      <= r_s4;
            r_out_duty <= pid_duty;
        end
    end

    always_comb begin
        pid_ctrl.ld2   = ld2;
        pid_ctrl.ld3   = ld3;
        pid_ctrl.ld4   = ld4;
        pid_ctrl.ldo   = ld_out;
        pid_ctrl.tick1 = r_s1.tick;
        pid_ctrl.tick4 = r_s4.tick;
    end

    qspc_pid u_pid (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (pid_ctrl),
        .i_target    (r_s1.target),
        .i_speed     (r_s1.speed),
        .i_kp        (r_kp),
        .i_ki        (r_ki),
        .i_kd        (r_kd),
        .i_drive_max (r_drive_max),
        .o_duty      (pid_duty)
    );

    assign o_rsp.valid            = r_ov;
    assign o_rsp.position_count   = r_out.pos;
    assign o_rsp.speed_magnitude  = r_out.speed;
    assign o_rsp.direction        = r_out.dir;
    assign o_rsp.drive_duty       = r_out_duty;
    assign o_rsp.speed_high_digit = r_out.high;
    assign o_rsp.speed_low_digit  = r_out.low;
    assign o_rsp.report_due       = r_out.report;

    // Configuration port.
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count_mode   <= COUNT_MODE_RST;
            r_kp           <= KP_GAIN_RST;
            r_ki           <= KI_GAIN_RST;
            r_kd           <= KD_GAIN_RST;
            r_drive_max    <= DRIVE_MAX_RST;
            r_report_every <= REPORT_EVERY_RST;
        end else if (cfg_wr) begin
            case (t_reg_idx'(paddr[4:2]))
                REG_COUNT_MODE:   r_count_mode   <= pwdata[0];
                REG_KP_GAIN:      r_kp           <= pwdata[15:0];
                REG_KI_GAIN:      r_ki           <= pwdata[15:0];
                REG_KD_GAIN:      r_kd           <= pwdata[15:0];
                REG_DRIVE_MAX:    r_drive_max    <= pwdata[9:0];
                REG_REPORT_EVERY: r_report_every <= pwdata[7:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (t_reg_idx'(paddr[4:2]))
            REG_COUNT_MODE:   prdata = {31'd0, r_count_mode};
            REG_KP_GAIN:      prdata = {16'd0, r_kp};
            REG_KI_GAIN:      prdata = {16'd0, r_ki};
            REG_KD_GAIN:      prdata = {16'd0, r_kd};
            REG_DRIVE_MAX:    prdata = {22'd0, r_drive_max};
            REG_REPORT_EVERY: prdata = {24'd0, r_report_every};
            default:          prdata = '0;
        endcase
    end

`ifndef SYNTHESIS
    a_tick_recenters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && i_req.req_type == REQ_TICK) |=> r_edge_count == COUNT_CENTER)
        else $error("position count not recentered after a tick");

    a_speed_saturated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_speed <= SPEED_MAX)
        else $error("latched speed above saturation limit");

    a_report_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && i_req.req_type == REQ_TICK && r_report_cnt == r_report_every)
        |=> r_report_cnt == 8'd0)
        else $error("report divider did not clear on a match");

    a_last_stage_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v4 && !ld_out) |=> r_v4)
        else $error("request dropped from the last pipeline stage");

    a_digits_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> (o_rsp.speed_low_digit < 8'd250 &&
        16'(o_rsp.speed_high_digit) * 16'd250 + 16'(o_rsp.speed_low_digit)
        == o_rsp.speed_magnitude))
        else $error("speed digits do not match the speed magnitude");
`endif

endmodule
